// File: design/crc_checked_frame_receiver_unit_defines.svh
// Assertion macros used by the frame receiver back end.
// No dependencies; pulled in by modules that carry assertions.
`ifndef CRC_CHECKED_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define CRC_CHECKED_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRCFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`endif

// File: design/crcfr_pkg.sv
// Shared types, codes and the CRC byte update for the frame receiver.
// No dependencies; used by every module of the block.
package crcfr_pkg;

    localparam int DATA_W      = 8;
    localparam int KIND_W      = 3;
    localparam int INDEX_W     = 9;
    localparam int STATUS_W    = 2;
    localparam int CRC_W       = 16;
    localparam int CFG_INDEX_W = 1;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // byte kinds
    localparam logic [KIND_W-1:0] KIND_LENGTH   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_COMMAND  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CRC_HIGH = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CRC_LOW  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ABORT    = 3'd5;

    // frame status
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SHORT   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_ABORTED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_POLY = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DOWNLINK = 1'd1;

    localparam logic [CRC_W-1:0]  CRC_POLY_RESET = 16'h1021;
    localparam logic [DATA_W-1:0] DOWNLINK_RESET = 8'h00;
    localparam logic [CRC_W-1:0]  CRC_INIT       = 16'h0000;
    localparam logic [DATA_W-1:0] MIN_LENGTH     = 8'd3;

    // one classified byte on its way from front to back
    typedef struct packed {
        logic [DATA_W-1:0]   data;
        logic [KIND_W-1:0]   kind;
        logic [INDEX_W-1:0]  index;
        logic                last;
        logic [STATUS_W-1:0] status;
        logic                have_cmd;
    } crcfr_entry_t;

    // MSB-first CRC update over one byte
    function automatic logic [CRC_W-1:0] crc_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [DATA_W-1:0] b,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0]  crc;
        logic [DATA_W-1:0] m;
        logic              top;
        crc = crc_in;
        m   = b;
        for (int k = 0; k < DATA_W; k++)
        begin
            top = m[DATA_W-1] ^ crc[CRC_W-1];
            crc = {crc[CRC_W-2:0], 1'b0};
            if (top)
            begin
                crc = crc ^ poly;
            end
            m = {m[DATA_W-2:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

// File: design/crcfr_front.sv
// Front end: accepts received bytes, tracks frame position and classifies.
// Depends on crcfr_pkg.
module crcfr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [crcfr_pkg::DATA_W-1:0]  rx_byte,
    input  logic                          abort_frame,
    input  logic                          queue_full,
    output logic                          push,
    output crcfr_pkg::crcfr_entry_t       push_entry
);

    localparam logic [crcfr_pkg::INDEX_W-1:0] POS_LENGTH  = 9'd2;
    localparam logic [crcfr_pkg::INDEX_W-1:0] POS_COMMAND = 9'd3;
    localparam logic [crcfr_pkg::INDEX_W-1:0] POS_PAYLOAD = 9'd4;

    logic [crcfr_pkg::INDEX_W-1:0] pos_reg, pos_next;
    logic [crcfr_pkg::DATA_W-1:0]  len_reg, len_next;
    logic [crcfr_pkg::INDEX_W-1:0] len_ext;
    logic                          accept;
    logic                          is_short;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign len_ext  = {1'b0, len_reg};
    assign is_short = rx_byte < crcfr_pkg::MIN_LENGTH;

    always_comb
    begin
        pos_next            = pos_reg;
        len_next            = len_reg;
        push                = 1'b0;
        push_entry.data     = rx_byte;
        push_entry.kind     = crcfr_pkg::KIND_PAYLOAD;
        push_entry.index    = pos_reg;
        push_entry.last     = 1'b0;
        push_entry.status   = crcfr_pkg::STATUS_OK;
        push_entry.have_cmd = 1'b0;
        if (accept)
        begin
            if (abort_frame)
            begin
                // drop the partial frame; mark it only if bytes went out
                pos_next = '0;
                len_next = '0;
                if (pos_reg >= POS_COMMAND)
                begin
                    push                = 1'b1;
                    push_entry.data     = '0;
                    push_entry.kind     = crcfr_pkg::KIND_ABORT;
                    push_entry.last     = 1'b1;
                    push_entry.status   = crcfr_pkg::STATUS_ABORTED;
                    push_entry.have_cmd = pos_reg >= POS_PAYLOAD;
                end
            end
            else if (pos_reg < POS_LENGTH)
            begin
                pos_next = pos_reg + 9'd1;
            end
            else if (pos_reg == POS_LENGTH)
            begin
                push            = 1'b1;
                push_entry.kind = crcfr_pkg::KIND_LENGTH;
                if (is_short)
                begin
                    push_entry.last   = 1'b1;
                    push_entry.status = crcfr_pkg::STATUS_SHORT;
                    pos_next          = '0;
                    len_next          = '0;
                end
                else
                begin
                    len_next = rx_byte;
                    pos_next = POS_COMMAND;
                end
            end
            else if (pos_reg == POS_COMMAND)
            begin
                push            = 1'b1;
                push_entry.kind = crcfr_pkg::KIND_COMMAND;
                pos_next        = POS_PAYLOAD;
            end
            else if (pos_reg <= len_ext)
            begin
                push            = 1'b1;
                push_entry.kind = crcfr_pkg::KIND_PAYLOAD;
                pos_next        = pos_reg + 9'd1;
            end
            else if (pos_reg == len_ext + 9'd1)
            begin
                push            = 1'b1;
                push_entry.kind = crcfr_pkg::KIND_CRC_HIGH;
                pos_next        = pos_reg + 9'd1;
            end
            else
            begin
                push            = 1'b1;
                push_entry.kind = crcfr_pkg::KIND_CRC_LOW;
                push_entry.last = 1'b1;
                pos_next        = '0;
                len_next        = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            len_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
        end
    end

endmodule

// File: design/crcfr_queue.sv
// Short request queue between the front end and the back end.
// Depends on crcfr_pkg for the entry type.
module crcfr_queue #(
    parameter int DEPTH = crcfr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  crcfr_pkg::crcfr_entry_t push_entry,
    output logic                    full,
    input  logic                    pop,
    output logic                    pop_valid,
    output crcfr_pkg::crcfr_entry_t pop_entry
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(DEPTH);

    crcfr_pkg::crcfr_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               do_push, do_pop;

    assign full      = count_reg == FULL_CNT;
    assign pop_valid = count_reg != '0;
    assign pop_entry = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - COUNT_W'(1);
            end
        end
    end

endmodule

// File: design/crcfr_back.sv
// Back end: runs the CRC, tracks the command and drives the result register.
// Depends on crcfr_pkg and the assertion macro header.
`include "crc_checked_frame_receiver_unit_defines.svh"

module crcfr_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pop_valid,
    input  crcfr_pkg::crcfr_entry_t         pop_entry,
    output logic                            pop,
    input  logic [crcfr_pkg::CRC_W-1:0]     crc_poly,
    input  logic [crcfr_pkg::DATA_W-1:0]    downlink_code,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [crcfr_pkg::DATA_W-1:0]    data_byte,
    output logic [crcfr_pkg::KIND_W-1:0]    byte_kind,
    output logic [crcfr_pkg::INDEX_W-1:0]   byte_index,
    output logic [crcfr_pkg::DATA_W-1:0]    frame_command,
    output logic                            last,
    output logic [crcfr_pkg::STATUS_W-1:0]  frame_status,
    output logic                            is_downlink
);

    logic [crcfr_pkg::CRC_W-1:0]    crc_reg, crc_next, crc_base, crc_upd;
    logic [crcfr_pkg::DATA_W-1:0]   cmd_reg, cmd_next;
    logic [crcfr_pkg::DATA_W-1:0]   crc_high_reg, crc_high_next;
    logic                           out_valid_reg, out_valid_next;
    logic [crcfr_pkg::DATA_W-1:0]   data_reg;
    logic [crcfr_pkg::KIND_W-1:0]   kind_reg;
    logic [crcfr_pkg::INDEX_W-1:0]  index_reg;
    logic [crcfr_pkg::DATA_W-1:0]   cmd_out_reg, cmd_out_next;
    logic                           last_reg;
    logic [crcfr_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                           downlink_reg, downlink_next;

    assign pop = pop_valid && (!out_valid_reg || !out_stall);

    // the length byte restarts the CRC
    assign crc_base = (pop_entry.kind == crcfr_pkg::KIND_LENGTH) ? crcfr_pkg::CRC_INIT
                                                                 : crc_reg;
    assign crc_upd  = crcfr_pkg::crc_byte(crc_base, pop_entry.data, crc_poly);

    always_comb
    begin
        crc_next      = crc_reg;
        cmd_next      = cmd_reg;
        crc_high_next = crc_high_reg;
        cmd_out_next  = cmd_reg;
        status_next   = pop_entry.status;
        downlink_next = 1'b0;
        if (pop)
        begin
            unique case (pop_entry.kind)
                crcfr_pkg::KIND_LENGTH:
                begin
                    crc_next      = crc_upd;
                    cmd_next      = '0;
                    crc_high_next = '0;
                    cmd_out_next  = '0;
                end
                crcfr_pkg::KIND_COMMAND:
                begin
                    crc_next     = crc_upd;
                    cmd_next     = pop_entry.data;
                    cmd_out_next = pop_entry.data;
                end
                crcfr_pkg::KIND_PAYLOAD:
                begin
                    crc_next = crc_upd;
                end
                crcfr_pkg::KIND_CRC_HIGH:
                begin
                    crc_high_next = pop_entry.data;
                end
                crcfr_pkg::KIND_CRC_LOW:
                begin
                    status_next   = ({crc_high_reg, pop_entry.data} == crc_reg)
                                    ? crcfr_pkg::STATUS_OK : crcfr_pkg::STATUS_CRC_ERR;
                    downlink_next = cmd_reg == downlink_code;
                end
                default:
                begin
                    // abort marker: command only if it was received
                    cmd_out_next  = pop_entry.have_cmd ? cmd_reg : '0;
                    downlink_next = pop_entry.have_cmd && (cmd_reg == downlink_code);
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= crcfr_pkg::CRC_INIT;
            cmd_reg       <= '0;
            crc_high_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            cmd_reg       <= cmd_next;
            crc_high_reg  <= crc_high_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded on each pop
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg     <= pop_entry.data;
            kind_reg     <= pop_entry.kind;
            index_reg    <= pop_entry.index;
            cmd_out_reg  <= cmd_out_next;
            last_reg     <= pop_entry.last;
            status_reg   <= status_next;
            downlink_reg <= downlink_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign data_byte     = data_reg;
    assign byte_kind     = kind_reg;
    assign byte_index    = index_reg;
    assign frame_command = cmd_out_reg;
    assign last          = last_reg;
    assign frame_status  = status_reg;
    assign is_downlink   = downlink_reg;

    `CRCFR_ASSERT_NOW(a_abort_is_final, clk, rst_n,
        out_valid_reg && (kind_reg == crcfr_pkg::KIND_ABORT),
        last_reg && (status_reg == crcfr_pkg::STATUS_ABORTED))
    `CRCFR_ASSERT_NOW(a_mid_frame_clean, clk, rst_n,
        out_valid_reg && !last_reg,
        (status_reg == crcfr_pkg::STATUS_OK) && !downlink_reg)
    `CRCFR_ASSERT_NOW(a_no_pop_when_held, clk, rst_n,
        out_valid_reg && out_stall, !pop)
    `CRCFR_ASSERT_NEXT(a_length_no_command, clk, rst_n,
        pop && (pop_entry.kind == crcfr_pkg::KIND_LENGTH),
        (cmd_out_reg == '0) && (cmd_reg == '0))

endmodule

// File: design/crc_checked_frame_receiver_unit.sv
// Top level of the CRC-checked frame receiver: config registers and wiring.
// Depends on crcfr_pkg, crcfr_front, crcfr_queue and crcfr_back.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one received byte per request,
//   with abort_frame marking a receive timeout. Output channel
//   (out_valid / out_stall) gives at most one result per input request:
//   every byte from the length byte onward, tagged with kind and index, and
//   a final result with last, frame_status and is_downlink.
//   Config channel (cfg_valid / cfg_ready) writes the CRC polynomial
//   (index 0) and the downlink command code (index 1); cfg_ready is always
//   high. Write config only while the block is idle.
//   Path: an accepted byte is written into the queue, then popped into the
//   result register, where it is held while out_stall is high.
//   Throughput: one byte per cycle while out_stall is low; the CRC byte
//   update is a combinational XOR network in the back end.
//   Reset: the front end hunts for a new frame, the queue empties, the
//   polynomial returns to 0x1021 and the downlink code to 0.
//   Receiver stall: the result register holds, the queue fills behind it,
//   and in_stall rises once QUEUE_DEPTH results are waiting in the queue.
module crc_checked_frame_receiver_unit #(
    parameter int QUEUE_DEPTH = crcfr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input requests
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [crcfr_pkg::DATA_W-1:0]        rx_byte,
    input  logic                                abort_frame,
    // result requests
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [crcfr_pkg::DATA_W-1:0]        data_byte,
    output logic [crcfr_pkg::KIND_W-1:0]        byte_kind,
    output logic [crcfr_pkg::INDEX_W-1:0]       byte_index,
    output logic [crcfr_pkg::DATA_W-1:0]        frame_command,
    output logic                                last,
    output logic [crcfr_pkg::STATUS_W-1:0]      frame_status,
    output logic                                is_downlink,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [crcfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [crcfr_pkg::CRC_W-1:0]         cfg_data
);

    logic [crcfr_pkg::CRC_W-1:0]  crc_poly_reg;
    logic [crcfr_pkg::DATA_W-1:0] downlink_code_reg;

    logic                    push;
    crcfr_pkg::crcfr_entry_t push_entry;
    logic                    queue_full;
    logic                    pop;
    logic                    pop_valid;
    crcfr_pkg::crcfr_entry_t pop_entry;

    // Config writes are always accepted.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_poly_reg      <= crcfr_pkg::CRC_POLY_RESET;
            downlink_code_reg <= crcfr_pkg::DOWNLINK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                crcfr_pkg::CFG_CRC_POLY: crc_poly_reg      <= cfg_data;
                crcfr_pkg::CFG_DOWNLINK: downlink_code_reg <= cfg_data[crcfr_pkg::DATA_W-1:0];
                default: ;
            endcase
        end
    end

    // Classify bytes by frame position.
    crcfr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .abort_frame (abort_frame),
        .queue_full  (queue_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    // Decouple the front end from output back-pressure.
    crcfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry)
    );

    // Run the CRC, resolve command and verdict, drive results.
    crcfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_entry     (pop_entry),
        .pop           (pop),
        .crc_poly      (crc_poly_reg),
        .downlink_code (downlink_code_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .data_byte     (data_byte),
        .byte_kind     (byte_kind),
        .byte_index    (byte_index),
        .frame_command (frame_command),
        .last          (last),
        .frame_status  (frame_status),
        .is_downlink   (is_downlink)
    );

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for crc_checked_frame_receiver_unit: frames, aborts, CRC settings.
// Depends on crcfr_pkg for port widths, byte kinds, status codes and register indexes.

module testbench;

    // Cycles with no request moving on any channel before the run is called hung.
    localparam int WATCHDOG_CYCLES = 1000;
    // Extra wait after the last awaited result has arrived.
    localparam int DRAIN_CYCLES    = 6;

    typedef logic [crcfr_pkg::DATA_W-1:0] byte_val_t;
    typedef logic [crcfr_pkg::CRC_W-1:0]  crc_val_t;

    // One expected result request, field for field as the output ports carry it.
    typedef struct packed {
        logic [crcfr_pkg::DATA_W-1:0]   data;
        logic [crcfr_pkg::KIND_W-1:0]   kind;
        logic [crcfr_pkg::INDEX_W-1:0]  index;
        logic [crcfr_pkg::DATA_W-1:0]   command;
        logic                           last_flag;
        logic [crcfr_pkg::STATUS_W-1:0] status;
        logic                           downlink;
    } frame_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [crcfr_pkg::DATA_W-1:0]      rx_byte = '0;
    logic                              abort_frame = 1'b0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [crcfr_pkg::DATA_W-1:0]      data_byte;
    logic [crcfr_pkg::KIND_W-1:0]      byte_kind;
    logic [crcfr_pkg::INDEX_W-1:0]     byte_index;
    logic [crcfr_pkg::DATA_W-1:0]      frame_command;
    logic                              last;
    logic [crcfr_pkg::STATUS_W-1:0]    frame_status;
    logic                              is_downlink;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [crcfr_pkg::CFG_INDEX_W-1:0] cfg_index = crcfr_pkg::CFG_CRC_POLY;
    logic [crcfr_pkg::CRC_W-1:0]       cfg_data = '0;

    // Receiver state as the bench tracks it, plus its copy of the two registers.
    logic [crcfr_pkg::INDEX_W-1:0] rx_position;
    logic [crcfr_pkg::DATA_W-1:0]  held_length;
    logic [crcfr_pkg::DATA_W-1:0]  held_command;
    logic [crcfr_pkg::CRC_W-1:0]   running_crc;
    logic [crcfr_pkg::DATA_W-1:0]  high_crc_byte;
    logic [crcfr_pkg::CRC_W-1:0]   poly_setting;
    logic [crcfr_pkg::DATA_W-1:0]  downlink_setting;

    frame_result_t awaited_results[$];

    int sent_items  = 0;
    int error_count = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    int send_burst  = 0;

    crc_checked_frame_receiver_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .abort_frame   (abort_frame),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .data_byte     (data_byte),
        .byte_kind     (byte_kind),
        .byte_index    (byte_index),
        .frame_command (frame_command),
        .last          (last),
        .frame_status  (frame_status),
        .is_downlink   (is_downlink),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Advance the CRC over one byte, MSB first, with the current polynomial.
    function automatic logic [crcfr_pkg::CRC_W-1:0] crc16_step(
        input logic [crcfr_pkg::CRC_W-1:0]  crc,
        input logic [crcfr_pkg::DATA_W-1:0] b
    );
        logic [crcfr_pkg::CRC_W-1:0] acc;
        logic                        feedback;
        int                          i;
        acc = crc;
        for (i = crcfr_pkg::DATA_W - 1; i >= 0; i--)
        begin
            feedback = acc[crcfr_pkg::CRC_W-1] ^ b[i];
            acc = {acc[crcfr_pkg::CRC_W-2:0], 1'b0} ^ (feedback ? poly_setting : '0);
        end
        return acc;
    endfunction

    // Drop whatever frame was in progress and hunt for the next preamble.
    function automatic void restart_hunt();
        rx_position   = '0;
        held_length   = '0;
        held_command  = '0;
        running_crc   = crcfr_pkg::CRC_INIT;
        high_crc_byte = '0;
    endfunction

    // Work out the result (if any) of one accepted byte request and queue it.
    function automatic void predict_received(input logic [crcfr_pkg::DATA_W-1:0] b,
                                             input logic ab);
        frame_result_t               r;
        logic [crcfr_pkg::CRC_W-1:0] got;
        r = '0;
        if (ab)
        begin
            // Only a frame that already passed its length byte out gets a marker.
            if (rx_position >= 9'd3)
            begin
                r.kind      = crcfr_pkg::KIND_ABORT;
                r.index     = rx_position;
                r.last_flag = 1'b1;
                r.status    = crcfr_pkg::STATUS_ABORTED;
                if (rx_position >= 9'd4)
                begin
                    r.command  = held_command;
                    r.downlink = (held_command == downlink_setting);
                end
                awaited_results.push_back(r);
            end
            restart_hunt();
        end
        else if (rx_position < 9'd2)
        begin
            // preamble: accept silently
            rx_position = rx_position + 9'd1;
        end
        else if (rx_position == 9'd2)
        begin
            r.data  = b;
            r.kind  = crcfr_pkg::KIND_LENGTH;
            r.index = 9'd2;
            if (b < crcfr_pkg::MIN_LENGTH)
            begin
                r.last_flag = 1'b1;
                r.status    = crcfr_pkg::STATUS_SHORT;
                restart_hunt();
            end
            else
            begin
                held_length = b;
                running_crc = crc16_step(crcfr_pkg::CRC_INIT, b);
                rx_position = 9'd3;
            end
            awaited_results.push_back(r);
        end
        else if (rx_position == 9'd3)
        begin
            held_command = b;
            running_crc  = crc16_step(running_crc, b);
            rx_position  = 9'd4;
            r.data    = b;
            r.kind    = crcfr_pkg::KIND_COMMAND;
            r.index   = 9'd3;
            r.command = b;
            awaited_results.push_back(r);
        end
        else
        begin
            r.data    = b;
            r.index   = rx_position;
            r.command = held_command;
            if (rx_position <= {1'b0, held_length})
            begin
                r.kind      = crcfr_pkg::KIND_PAYLOAD;
                running_crc = crc16_step(running_crc, b);
                rx_position = rx_position + 9'd1;
            end
            else if (rx_position == {1'b0, held_length} + 9'd1)
            begin
                r.kind        = crcfr_pkg::KIND_CRC_HIGH;
                high_crc_byte = b;
                rx_position   = rx_position + 9'd1;
            end
            else
            begin
                got         = {high_crc_byte, b};
                r.kind      = crcfr_pkg::KIND_CRC_LOW;
                r.last_flag = 1'b1;
                r.status    = (got == running_crc) ? crcfr_pkg::STATUS_OK
                                                   : crcfr_pkg::STATUS_CRC_ERR;
                r.downlink  = (held_command == downlink_setting);
                restart_hunt();
            end
            awaited_results.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Idling
    // ------------------------------------------------------------------

    // Mostly no pause, some short ones, a few long ones.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Receiver stall: random bursts of stall, with occasional long stall-free stretches.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
        end
        else if (out_stall === 1'b1)
        begin
            out_stall <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 5);
        end
        else
        begin
            stall_left = pick_pause();
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        error_count++;
    endtask

    // Compare every accepted result request with the oldest awaited one.
    always @(posedge clk)
    begin : check_results
        frame_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (awaited_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d index %0d data %02h",
                                          byte_kind, byte_index, data_byte));
            end
            else
            begin
                want = awaited_results.pop_front();
                if (data_byte !== want.data)
                    report_mismatch($sformatf("data_byte %02h, want %02h (index %0d)",
                                              data_byte, want.data, want.index));
                if (byte_kind !== want.kind)
                    report_mismatch($sformatf("byte_kind %0d, want %0d (index %0d)",
                                              byte_kind, want.kind, want.index));
                if (byte_index !== want.index)
                    report_mismatch($sformatf("byte_index %0d, want %0d",
                                              byte_index, want.index));
                if (frame_command !== want.command)
                    report_mismatch($sformatf("frame_command %02h, want %02h (index %0d)",
                                              frame_command, want.command, want.index));
                if (last !== want.last_flag)
                    report_mismatch($sformatf("last %b, want %b (index %0d)",
                                              last, want.last_flag, want.index));
                if (frame_status !== want.status)
                    report_mismatch($sformatf("frame_status %0d, want %0d (index %0d)",
                                              frame_status, want.status, want.index));
                if (is_downlink !== want.downlink)
                    report_mismatch($sformatf("is_downlink %b, want %b (index %0d)",
                                              is_downlink, want.downlink, want.index));
            end
        end
    end

    // Watchdog: end the run once no channel has moved a request for too long.
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0) ||
            (cfg_valid === 1'b1 && cfg_ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one byte request. Valid stays high after acceptance; the next call
    // either replaces the payload at once or drops valid for a pause first.
    task automatic send_request(input logic [crcfr_pkg::DATA_W-1:0] b, input logic ab);
        int pause;
        if (send_burst > 0)
        begin
            send_burst--;
            pause = 0;
        end
        else
        begin
            if ($urandom_range(0, 19) == 0)
                send_burst = $urandom_range(20, 80);
            pause = pick_pause();
        end
        if (pause > 0)
        begin
            in_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        in_valid    <= 1'b1;
        rx_byte     <= b;
        abort_frame <= ab;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_received(b, ab);
        sent_items++;
    endtask

    // Send one frame of length len. A corrupt frame flips one CRC bit; abort_at
    // replaces the byte at that position by an abort request (-1 for none).
    task automatic send_frame(input logic [crcfr_pkg::DATA_W-1:0] len,
                              input logic [crcfr_pkg::DATA_W-1:0] cmd,
                              input bit corrupt, input int abort_at);
        logic [crcfr_pkg::DATA_W-1:0] frame_bytes[$];
        logic [crcfr_pkg::CRC_W-1:0]  crc;
        int                           p;
        // resync first if a previous sequence left a frame open
        if (rx_position != 0)
            send_request(byte_val_t'($urandom), 1'b1);
        frame_bytes.push_back(byte_val_t'($urandom));
        frame_bytes.push_back(byte_val_t'($urandom));
        frame_bytes.push_back(len);
        if (len >= crcfr_pkg::MIN_LENGTH)
        begin
            frame_bytes.push_back(cmd);
            for (p = 3; p < len; p++)
                frame_bytes.push_back(byte_val_t'($urandom));
            crc = crcfr_pkg::CRC_INIT;
            for (p = 2; p < frame_bytes.size(); p++)
                crc = crc16_step(crc, frame_bytes[p]);
            if (corrupt)
                crc = crc ^ (16'h0001 << $urandom_range(0, 15));
            frame_bytes.push_back(crc[15:8]);
            frame_bytes.push_back(crc[7:0]);
        end
        for (p = 0; p < frame_bytes.size(); p++)
        begin
            if (p == abort_at)
            begin
                send_request(byte_val_t'($urandom), 1'b1);
                break;
            end
            send_request(frame_bytes[p], 1'b0);
        end
    endtask

    // Drop valid, let every awaited result arrive, then let silent requests settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register; cfg_valid is left high so back-to-back writes need no toggle.
    task automatic write_register(input logic [crcfr_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [crcfr_pkg::CRC_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == crcfr_pkg::CFG_CRC_POLY)
            poly_setting = value;
        else
            downlink_setting = value[crcfr_pkg::DATA_W-1:0];
    endtask

    task automatic apply_settings(input logic [crcfr_pkg::CRC_W-1:0] poly,
                                  input logic [crcfr_pkg::DATA_W-1:0] code);
        wait_idle();
        write_register(crcfr_pkg::CFG_CRC_POLY, poly);
        write_register(crcfr_pkg::CFG_DOWNLINK, {8'h00, code});
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Length bytes below the minimum end the frame at once with a short status.
    task automatic test_short_lengths();
        send_frame(8'd0, 8'h00, 1'b0, -1);
        send_frame(8'd2, 8'hFF, 1'b0, -1);
    endtask

    // Smallest frame (no payload) as downlink, then a one-byte payload with a bad CRC.
    task automatic test_minimal_frames();
        send_frame(crcfr_pkg::MIN_LENGTH, downlink_setting, 1'b0, -1);
        send_frame(8'd4, 8'hFF, 1'b1, -1);
    endtask

    // Abort while hunting, inside the preamble, and right after the length byte.
    task automatic test_aborts();
        send_request(8'hFF, 1'b1);
        send_frame(8'd9, 8'h5A, 1'b0, 1);
        send_frame(8'd7, 8'h00, 1'b0, 3);
    endtask

    // Largest length byte: 252 payload bytes, last index 257.
    task automatic test_longest_frame();
        send_frame(8'd255, 8'hC3, 1'b0, -1);
    endtask

    // Mostly well-formed frames with random content; the rest bad CRCs, aborts at
    // random positions, short lengths and loose noise bytes.
    task automatic test_random_traffic(input int budget);
        int                           start;
        int                           pick;
        int                           len;
        logic [crcfr_pkg::DATA_W-1:0] cmd;
        start = sent_items;
        while (sent_items - start < budget)
        begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 255)
                                                : $urandom_range(3, 24);
            cmd  = ($urandom_range(0, 2) == 0) ? downlink_setting : byte_val_t'($urandom);
            if (pick < 65)
                send_frame(byte_val_t'(len), cmd, 1'b0, -1);
            else if (pick < 77)
                send_frame(byte_val_t'(len), cmd, 1'b1, -1);
            else if (pick < 89)
                send_frame(byte_val_t'(len), cmd, 1'b0, $urandom_range(0, len + 2));
            else if (pick < 94)
                send_frame(byte_val_t'($urandom_range(0, 2)), cmd, 1'b0, -1);
            else
                repeat ($urandom_range(1, 8))
                    send_request(byte_val_t'($urandom), $urandom_range(0, 7) == 0);
        end
        // close any open frame so the next settings start from a clean hunt
        if (rx_position != 0)
            send_request(byte_val_t'($urandom), 1'b1);
    endtask

    initial
    begin
        poly_setting     = crcfr_pkg::CRC_POLY_RESET;
        downlink_setting = crcfr_pkg::DOWNLINK_RESET;
        restart_hunt();

        // hold reset, then release it on an edge
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings first
        test_short_lengths();
        test_minimal_frames();
        test_aborts();
        test_longest_frame();
        test_random_traffic(300);

        // sweep the registers, extremes included
        apply_settings(16'hFFFF, 8'hFF);
        test_random_traffic(300);
        apply_settings(16'h0000, byte_val_t'($urandom));
        test_random_traffic(300);
        apply_settings(crc_val_t'($urandom), 8'h00);
        test_random_traffic(300);
        apply_settings(16'h8005, byte_val_t'($urandom));
        test_random_traffic(300);

        wait_idle();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/crcfr_pkg.sv
design/crcfr_front.sv
design/crcfr_queue.sv
design/crcfr_back.sv
design/crc_checked_frame_receiver_unit.sv
test/testbench.sv
